// File: hw/rtl/rgbq_pkg.sv
// ----------------------------------------------------------------------------
// rgbq_pkg
// Types, palette and shade ramp shared by the ANSI-16 shade quantizer.
// ----------------------------------------------------------------------------
package rgbq_pkg;

	localparam int unsigned NUM_COLORS = 16;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned DIST_W     = 9;
	localparam int unsigned RAMP_LEN   = 13;
	localparam int unsigned LEVEL_W    = 4;
	localparam int unsigned CHAR_W     = 7;

	localparam logic [IDX_W-1:0]  WHITE_IDX  = 4'd15;
	localparam logic [DIST_W-1:0] DIST_INIT  = 9'd256;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd12;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [3:0] palette_index;
		logic [3:0] shade_level;
		logic [6:0] shade_char;
	} result_t;

	// what moves from one cell to the next
	typedef struct packed {
		pixel_t            px;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] score;
	} beat_t;

	function automatic pixel_t rgbq_color(input logic [IDX_W-1:0] k);
		pixel_t c;
		case (k)
			4'd0:    c = '{8'h00, 8'h00, 8'h00};
			4'd1:    c = '{8'h18, 8'h18, 8'hc2};
			4'd2:    c = '{8'h18, 8'hc2, 8'h18};
			4'd3:    c = '{8'h18, 8'hc2, 8'hc2};
			4'd4:    c = '{8'hc2, 8'h18, 8'h18};
			4'd5:    c = '{8'hc2, 8'h18, 8'hc2};
			4'd6:    c = '{8'hc2, 8'hc2, 8'h18};
			4'd7:    c = '{8'hc2, 8'hc2, 8'hc2};
			4'd8:    c = '{8'h68, 8'h68, 8'h68};
			4'd9:    c = '{8'h74, 8'h74, 8'hff};
			4'd10:   c = '{8'h54, 8'hff, 8'h54};
			4'd11:   c = '{8'h54, 8'hff, 8'hff};
			4'd12:   c = '{8'hff, 8'h54, 8'h54};
			4'd13:   c = '{8'hff, 8'h54, 8'hff};
			4'd14:   c = '{8'hff, 8'hff, 8'h54};
			default: c = '{8'hff, 8'hff, 8'hff};
		endcase
		return c;
	endfunction

	// ramp "%@&#$=+<;:-. "
	function automatic logic [CHAR_W-1:0] rgbq_ramp(input logic [LEVEL_W-1:0] lvl);
		logic [CHAR_W-1:0] ch;
		case (lvl)
			4'd0:    ch = 7'd37;
			4'd1:    ch = 7'd64;
			4'd2:    ch = 7'd38;
			4'd3:    ch = 7'd35;
			4'd4:    ch = 7'd36;
			4'd5:    ch = 7'd61;
			4'd6:    ch = 7'd43;
			4'd7:    ch = 7'd60;
			4'd8:    ch = 7'd59;
			4'd9:    ch = 7'd58;
			4'd10:   ch = 7'd45;
			4'd11:   ch = 7'd46;
			default: ch = 7'd32;
		endcase
		return ch;
	endfunction

endpackage

// File: hw/rtl/rgbq_cell.sv
// ----------------------------------------------------------------------------
// rgbq_cell
// One palette entry: tests the pixel against it and keeps the better match.
// ----------------------------------------------------------------------------
module rgbq_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  rgbq_pkg::beat_t up_beat,
	output logic           dn_valid,
	input  logic           dn_ready,
	output rgbq_pkg::beat_t dn_beat
);
	import rgbq_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam pixel_t ENTRY = rgbq_color(MY_IDX);

	logic       valid_q;
	beat_t      beat_q;
	logic       ok;
	logic [7:0] gap_r, gap_g, gap_b, worst_rg, worst;
	beat_t      nxt;

	always_comb begin
		ok       = (ENTRY.red >= up_beat.px.red) && (ENTRY.green >= up_beat.px.green)
			&& (ENTRY.blue >= up_beat.px.blue);
		gap_r    = ENTRY.red - up_beat.px.red;
		gap_g    = ENTRY.green - up_beat.px.green;
		gap_b    = ENTRY.blue - up_beat.px.blue;
		worst_rg = (gap_r > gap_g) ? gap_r : gap_g;
		worst    = (worst_rg > gap_b) ? worst_rg : gap_b;
		nxt      = up_beat;
		// strict compare keeps the lower index on a tie
		if (ok && ({1'b0, worst} < up_beat.score)) begin
			nxt.idx   = MY_IDX;
			nxt.score = {1'b0, worst};
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			beat_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_beat  = beat_q;

endmodule

// File: hw/rtl/rgbq_shade.sv
// ----------------------------------------------------------------------------
// rgbq_shade
// Output stage: maps the winning distance to a shade level and ramp character.
// ----------------------------------------------------------------------------
module rgbq_shade (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  rgbq_pkg::beat_t  up_beat,
	output logic             out_valid,
	input  logic             out_ready,
	output rgbq_pkg::result_t out_data
);
	import rgbq_pkg::*;

	logic              valid_q;
	result_t           res_q;
	logic [12:0]       prod;
	logic [LEVEL_W-1:0] lvl;
	result_t           nxt;

	always_comb begin
		// score * 13 as shifts and adds
		prod = {1'b0, up_beat.score, 3'b000} + {2'b00, up_beat.score, 2'b00}
			+ {4'b0000, up_beat.score};
		lvl  = (prod[12:8] > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : prod[11:8];
		nxt.palette_index = up_beat.idx;
		nxt.shade_level   = lvl;
		nxt.shade_char    = rgbq_ramp(lvl);
	end

	assign up_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			res_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = res_q;

endmodule

// File: hw/rtl/rgb_to_ansi16_shade_quantizer_top.sv
// ----------------------------------------------------------------------------
// rgb_to_ansi16_shade_quantizer_top
// Nearest ANSI-16 color with shade character, one pixel per unstalled cycle.
// ----------------------------------------------------------------------------
// in_valid/in_ready/in_data carry one pixel (red, green, blue) per beat;
// out_valid/out_ready/out_data carry palette_index, shade_level, shade_char.
// The pixel walks down a row of 16 cells, one per palette entry, each one
// registered; every cell keeps the closer qualifying color, lower index on
// ties. A final stage turns the winning distance into the shade level and
// ramp character and holds the result in the output register.
// Throughput is one pixel per cycle while the receiver keeps out_ready high;
// every stage is its own register, so the row drains independently and
// input is taken as long as any stage has a hole.
// When the receiver stalls the beats pile up behind the output register and
// in_ready drops only once all 17 stages are full.
// Reset clears all valid flags; no results are pending after reset.
// ----------------------------------------------------------------------------
module rgb_to_ansi16_shade_quantizer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rgbq_pkg::pixel_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rgbq_pkg::result_t out_data
);
	import rgbq_pkg::*;

	logic  ch_valid [NUM_COLORS+1];
	logic  ch_ready [NUM_COLORS+1];
	beat_t ch_beat  [NUM_COLORS+1];

	assign ch_valid[0]   = in_valid;
	assign in_ready      = ch_ready[0];
	assign ch_beat[0].px    = in_data;
	assign ch_beat[0].idx   = WHITE_IDX;
	assign ch_beat[0].score = DIST_INIT;

	for (genvar k = 0; k < NUM_COLORS; k++) begin : g_cell
		rgbq_cell #(
			.IDX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(ch_valid[k]),
			.up_ready(ch_ready[k]),
			.up_beat (ch_beat[k]),
			.dn_valid(ch_valid[k+1]),
			.dn_ready(ch_ready[k+1]),
			.dn_beat (ch_beat[k+1])
		);
	end

	rgbq_shade u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (ch_valid[NUM_COLORS]),
		.up_ready (ch_ready[NUM_COLORS]),
		.up_beat  (ch_beat[NUM_COLORS]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// back-pressure reaches the input only with the whole row full and stalled
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while the row still has room");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.shade_level <= LEVEL_MAX))
		else $error("shade level out of range");

	a_char_matches_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.shade_char == rgbq_ramp(out_data.shade_level)))
		else $error("shade character does not match level");

	// a pending result is never dropped during a stall
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output beat lost while stalled");

endmodule

// File: tb/sv/rgbq_shade_checker.sv
// ----------------------------------------------------------------------------
// rgbq_shade_checker
// Watches both channels of the shade quantizer, predicts each result and
// compares it field by field with what comes out, in order.
// ----------------------------------------------------------------------------
module rgbq_shade_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  rgbq_pkg::pixel_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  rgbq_pkg::result_t out_data,
	output int                fail_count,
	output int                shades_owed
);

	timeunit 1ns;
	timeprecision 1ps;

	import rgbq_pkg::*;

	localparam int REPORT_CAP = 100;

	// palette as {red, green, blue}
	localparam logic [23:0] ANSI_COLORS [16] = '{
		24'h000000, 24'h1818c2, 24'h18c218, 24'h18c2c2,
		24'hc21818, 24'hc218c2, 24'hc2c218, 24'hc2c2c2,
		24'h686868, 24'h7474ff, 24'h54ff54, 24'h54ffff,
		24'hff5454, 24'hff54ff, 24'hffff54, 24'hffffff
	};
	localparam logic [8*13-1:0] SHADE_TEXT = "%@&#$=+<;:-. ";

	result_t expected_shades[$];

	function automatic result_t nearest_shade(input pixel_t p);
		int unsigned best_dist;
		int unsigned best_k;
		int unsigned gap;
		int unsigned worst;
		int unsigned lvl;
		logic [7:0]  ent;
		logic [7:0]  pc;
		bit          fits;
		result_t     r;
		best_dist = 256;
		best_k = WHITE_IDX;
		for (int k = 0; k < 16; k++) begin
			fits = 1'b1;
			worst = 0;
			for (int c = 0; c < 3; c++) begin
				ent = ANSI_COLORS[k][8*(2-c) +: 8];
				pc = (c == 0) ? p.red : (c == 1) ? p.green : p.blue;
				if (ent < pc) begin
					fits = 1'b0;
				end else begin
					gap = ent - pc;
					if (gap > worst)
						worst = gap;
				end
			end
			// strict compare keeps the lower index on a tie
			if (fits && worst < best_dist) begin
				best_dist = worst;
				best_k = k;
			end
		end
		lvl = best_dist * RAMP_LEN / 256;
		if (lvl > LEVEL_MAX)
			lvl = LEVEL_MAX;
		r.palette_index = best_k[3:0];
		r.shade_level = lvl[3:0];
		r.shade_char = SHADE_TEXT[8*(RAMP_LEN-1-lvl) +: 7];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int      errs;
		int      delta;
		result_t want;
		if (!arst_n) begin
			expected_shades.delete();
			fail_count <= 0;
			shades_owed <= 0;
		end else begin
			errs = 0;
			delta = 0;
			if (out_valid && out_ready) begin
				if (expected_shades.size() == 0) begin
					errs++;
					if (fail_count < REPORT_CAP)
						$error("result beat with no pixel pending: %p", out_data);
				end else begin
					want = expected_shades.pop_front();
					delta--;
					if (out_data.palette_index !== want.palette_index) begin
						errs++;
						if (fail_count < REPORT_CAP)
							$error("palette_index: expected %0d, got %0d",
								want.palette_index, out_data.palette_index);
					end
					if (out_data.shade_level !== want.shade_level) begin
						errs++;
						if (fail_count < REPORT_CAP)
							$error("shade_level: expected %0d, got %0d",
								want.shade_level, out_data.shade_level);
					end
					if (out_data.shade_char !== want.shade_char) begin
						errs++;
						if (fail_count < REPORT_CAP)
							$error("shade_char: expected %0d, got %0d",
								want.shade_char, out_data.shade_char);
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_shades.push_back(nearest_shade(in_data));
				delta++;
			end
			fail_count <= fail_count + errs;
			shades_owed <= shades_owed + delta;
		end
	end

endmodule

// File: tb/sv/tb_rgb_to_ansi16_shade_quantizer_top.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_ansi16_shade_quantizer_top
// Drives pixels into the quantizer with random gaps and output stalls: a
// directed set of palette colors and edge pixels, then random pixels biased
// toward the palette boundaries. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_rgb_to_ansi16_shade_quantizer_top;

	timeunit 1ns;
	timeprecision 1ps;

	import rgbq_pkg::*;

	localparam int RANDOM_PIXELS = 1800;
	localparam int CALM_TAIL     = 300;
	localparam int STALL_LIMIT   = 500;
	localparam int DRAIN_CYCLES  = 40;

	localparam logic [23:0] ANSI_SEEDS [16] = '{
		24'h000000, 24'h1818c2, 24'h18c218, 24'h18c2c2,
		24'hc21818, 24'hc218c2, 24'hc2c218, 24'hc2c2c2,
		24'h686868, 24'h7474ff, 24'h54ff54, 24'h54ffff,
		24'hff5454, 24'hff54ff, 24'hffff54, 24'hffffff
	};
	// values right at and just past the palette components
	localparam logic [7:0] EDGE_BYTES [12] = '{
		8'h00, 8'h18, 8'h19, 8'h54, 8'h55, 8'h68,
		8'h69, 8'h74, 8'h75, 8'hc2, 8'hc3, 8'hff
	};

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	pixel_t  in_data;
	logic    out_valid;
	logic    out_ready;
	result_t out_data;
	int      fail_count;
	int      shades_owed;
	bit      calm;
	int      idle_cycles;

	rgb_to_ansi16_shade_quantizer_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	rgbq_shade_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.shades_owed(shades_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] nudge(input logic [7:0] v);
		int n;
		n = int'(v) - int'($urandom_range(0, 20));
		if ($urandom_range(0, 4) == 0)
			n = int'(v) + 1;
		if (n < 0)
			n = 0;
		if (n > 255)
			n = 255;
		return n[7:0];
	endfunction

	function automatic pixel_t pick_pixel();
		pixel_t      p;
		logic [23:0] col;
		case ($urandom_range(0, 2))
			0: p = pixel_t'(24'($urandom));
			1: begin
				col = ANSI_SEEDS[$urandom_range(0, 15)];
				p.red = nudge(col[23:16]);
				p.green = nudge(col[15:8]);
				p.blue = nudge(col[7:0]);
			end
			default: begin
				p.red = EDGE_BYTES[$urandom_range(0, 11)];
				p.green = EDGE_BYTES[$urandom_range(0, 11)];
				p.blue = EDGE_BYTES[$urandom_range(0, 11)];
			end
		endcase
		return p;
	endfunction

	task automatic send_pixel(input pixel_t p);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// receiver: short stall bursts, with the odd long stretch of no stalls
	initial begin
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat (40) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// watchdog: cycles with work outstanding but no beat moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(!in_valid && shades_owed == 0)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		pixel_t directed[$];
		directed = {};
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every palette color exactly, then edge pixels
		for (int k = 0; k < 16; k++)
			directed.push_back(pixel_t'(ANSI_SEEDS[k]));
		directed.push_back(pixel_t'(24'h010101));
		directed.push_back(pixel_t'(24'hc3c3c3)); // only white fits
		directed.push_back(pixel_t'(24'hfffffe));
		directed.push_back(pixel_t'(24'h00ff00));
		directed.push_back(pixel_t'(24'h80_00_ff));
		directed.push_back(pixel_t'(24'hff0000));
		directed.push_back(pixel_t'(24'h181818));
		directed.push_back(pixel_t'(24'h5555ff));
		foreach (directed[i])
			send_pixel(directed[i]);

		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			if (n == RANDOM_PIXELS - CALM_TAIL)
				calm = 1'b1;
			send_pixel(pick_pixel());
		end
		in_valid <= 1'b0;

		// let the last beat show up in the owed count before waiting on it
		@(posedge clk);
		while (shades_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
